### sv/dst_pkg.sv
package dst_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = 11;
  localparam int unsigned TagW = 32;

  localparam logic [1:0] CmdAdd = 2'd0;
  localparam logic [1:0] CmdDel = 2'd1;
  localparam logic [1:0] CmdMatch = 2'd2;
  localparam logic [1:0] CmdBad = 2'd3;

  localparam logic [1:0] AlgoMd5 = 2'd0;
  localparam logic [1:0] AlgoSha1 = 2'd1;
  localparam logic [1:0] AlgoSha256 = 2'd2;
  localparam logic [1:0] AlgoBad = 2'd3;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadCmd = 3'd1;
  localparam logic [2:0] StBadAlgo = 3'd2;
  localparam logic [2:0] StExists = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [2:0] StNotFound = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  algo;
    logic [31:0] name_tag;
    logic [63:0] md5_high;
    logic [63:0] md5_low;
    logic [63:0] sha1_high;
    logic [63:0] sha1_mid;
    logic [31:0] sha1_low;
    logic [63:0] sha256_word3;
    logic [63:0] sha256_word2;
    logic [63:0] sha256_word1;
    logic [63:0] sha256_word0;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic            found;
    logic [31:0]     found_tag;
    logic [CntW-1:0] total_entries;
    logic [CntW-1:0] md5_entries;
    logic [CntW-1:0] sha1_entries;
    logic [CntW-1:0] sha256_entries;
  } rsp_t;

  // algorithm code plus four digest words
  typedef struct packed {
    logic [1:0]  algo;
    logic [63:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } key_t;

  function automatic key_t pack_key(req_t r, logic [1:0] a);
    key_t k;
    k = '0;
    k.algo = a;
    unique case (a)
      AlgoMd5: begin
        k.w1 = r.md5_high;
        k.w0 = r.md5_low;
      end
      AlgoSha1: begin
        k.w2 = r.sha1_high;
        k.w1 = r.sha1_mid;
        k.w0 = {32'd0, r.sha1_low};
      end
      default: begin
        k.w3 = r.sha256_word3;
        k.w2 = r.sha256_word2;
        k.w1 = r.sha256_word1;
        k.w0 = r.sha256_word0;
      end
    endcase
    return k;
  endfunction

endpackage

### sv/dst_store.sv
// slot memory: one read port with registered data, one write port
module dst_store (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [dst_pkg::IdxW-1:0] rd_addr_i,
  output logic                   rd_valid_o,
  output dst_pkg::key_t          rd_key_o,
  output logic [dst_pkg::TagW-1:0] rd_tag_o,
  input  logic                   wr_en_i,
  input  logic [dst_pkg::IdxW-1:0] wr_addr_i,
  input  logic                   wr_valid_i,
  input  dst_pkg::key_t          wr_key_i,
  input  logic [dst_pkg::TagW-1:0] wr_tag_i
);
  import dst_pkg::*;

  logic            valid_mem [TableEntries];
  key_t            key_mem [TableEntries];
  logic [TagW-1:0] tag_mem [TableEntries];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      valid_mem[wr_addr_i] <= wr_valid_i;
      key_mem[wr_addr_i]   <= wr_key_i;
      tag_mem[wr_addr_i]   <= wr_tag_i;
    end
    if (rd_en_i) begin
      rd_valid_o <= valid_mem[rd_addr_i];
      rd_key_o   <= key_mem[rd_addr_i];
      rd_tag_o   <= tag_mem[rd_addr_i];
    end
  end
endmodule

### sv/digest_signature_table.sv
// latency: bad command or algorithm answers the cycle after acceptance; a scan reads one
// slot a cycle and compares it once its registered data is back; a hit ends the scan,
// an add or delete miss scans all 1024 slots, and a match tries md5, then sha1, then
// sha256, scanning every slot of each digest it misses and stopping at the first hit
// throughput: one transaction at a time, next accepted the cycle after the result is taken
// reset (asynchronous, active low) starts a pass clearing every slot's valid bit
module digest_signature_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dst_pkg::req_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dst_pkg::rsp_t   out_data_o
);
  import dst_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_CHECK, S_DONE, S_OUT
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [1:0]        algo_q;
  logic [IdxW:0]     idx_q;      // address issued this cycle
  logic [IdxW:0]     cmp_idx_q;  // address whose data is on the read port
  logic              rd_live_q;
  logic [CntW-1:0]   total_q;
  logic [CntW-1:0]   cnt_q [3];
  logic              hit_q;
  logic [IdxW-1:0]   hit_idx_q;
  logic [TagW-1:0]   hit_tag_q;
  logic              free_q;
  logic [IdxW-1:0]   free_idx_q;
  rsp_t              rsp_q;

  logic            rd_valid;
  key_t            rd_key;
  logic [TagW-1:0] rd_tag;
  key_t            probe_key;
  logic            rd_en;
  logic            add_ok;
  logic            del_ok;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic            cmp_hit;
  logic            cmp_free;
  rsp_t            done_rsp;

  assign probe_key = pack_key(req_q, algo_q);
  assign rd_en     = (state_q == S_SCAN) && !idx_q[IdxW];
  assign add_ok    = (state_q == S_DONE) && (req_q.cmd == CmdAdd) && !hit_q && free_q
                     && (total_q < CntW'(TableEntries));
  assign del_ok    = (state_q == S_DONE) && (req_q.cmd == CmdDel) && hit_q;
  assign wr_en     = (state_q == S_CLEAR) || add_ok || del_ok;
  assign wr_addr   = (state_q == S_CLEAR) ? idx_q[IdxW-1:0] :
                     (add_ok ? free_idx_q : hit_idx_q);
  assign cmp_hit   = rd_live_q && rd_valid && (rd_key == probe_key);
  assign cmp_free  = rd_live_q && !rd_valid;

  dst_store u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (idx_q[IdxW-1:0]),
    .rd_valid_o (rd_valid),
    .rd_key_o   (rd_key),
    .rd_tag_o   (rd_tag),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_valid_i (add_ok),
    .wr_key_i   (probe_key),
    .wr_tag_i   (req_q.name_tag)
  );

  // result and counts at the end of a scan
  always_comb begin
    done_rsp = '{status: StOk, found: 1'b0, found_tag: '0,
                 total_entries: total_q, md5_entries: cnt_q[0],
                 sha1_entries: cnt_q[1], sha256_entries: cnt_q[2]};
    if (req_q.cmd == CmdMatch) begin
      done_rsp.found     = hit_q;
      done_rsp.found_tag = hit_q ? hit_tag_q : '0;
    end else if (req_q.cmd == CmdAdd) begin
      if (hit_q) done_rsp.status = StExists;
      else if (!add_ok) done_rsp.status = StFull;
      else begin
        done_rsp.total_entries = total_q + CntW'(1);
        unique case (algo_q)
          AlgoMd5:  done_rsp.md5_entries    = cnt_q[0] + CntW'(1);
          AlgoSha1: done_rsp.sha1_entries   = cnt_q[1] + CntW'(1);
          default:  done_rsp.sha256_entries = cnt_q[2] + CntW'(1);
        endcase
      end
    end else begin
      if (!hit_q) done_rsp.status = StNotFound;
      else begin
        done_rsp.total_entries = total_q - CntW'(1);
        unique case (algo_q)
          AlgoMd5:  done_rsp.md5_entries    = cnt_q[0] - CntW'(1);
          AlgoSha1: done_rsp.sha1_entries   = cnt_q[1] - CntW'(1);
          default:  done_rsp.sha256_entries = cnt_q[2] - CntW'(1);
        endcase
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      req_q      <= '0;
      total_q    <= '0;
      cnt_q      <= '{default: '0};
      rd_live_q  <= 1'b0;
      idx_q      <= '0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      hit_tag_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      algo_q     <= '0;
      rsp_q      <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          // clear one valid bit per cycle
          idx_q <= idx_q + (IdxW+1)'(1);
          if (idx_q[IdxW-1:0] == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q     <= in_data_i;
            idx_q     <= '0;
            rd_live_q <= 1'b0;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            algo_q    <= (in_data_i.cmd == CmdMatch) ? AlgoMd5 : in_data_i.algo;
            if (in_data_i.cmd == CmdBad) begin
              rsp_q   <= '{status: StBadCmd, found: 1'b0, found_tag: '0,
                           total_entries: total_q, md5_entries: cnt_q[0],
                           sha1_entries: cnt_q[1], sha256_entries: cnt_q[2]};
              state_q <= S_OUT;
            end else if (in_data_i.cmd != CmdMatch && in_data_i.algo == AlgoBad) begin
              rsp_q   <= '{status: StBadAlgo, found: 1'b0, found_tag: '0,
                           total_entries: total_q, md5_entries: cnt_q[0],
                           sha1_entries: cnt_q[1], sha256_entries: cnt_q[2]};
              state_q <= S_OUT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_live_q <= rd_en;
          cmp_idx_q <= idx_q;
          if (rd_en) idx_q <= idx_q + (IdxW+1)'(1);
          // first free slot, seen in address order
          if (cmp_free && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= cmp_idx_q[IdxW-1:0];
          end
          if (cmp_hit) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cmp_idx_q[IdxW-1:0];
            hit_tag_q <= rd_tag;
            state_q   <= S_DONE;
          end else if (!rd_live_q && idx_q[IdxW]) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          // scan missed: try the next algorithm for a match
          if (req_q.cmd == CmdMatch && algo_q != AlgoSha256) begin
            algo_q  <= algo_q + 2'd1;
            idx_q   <= '0;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          rsp_q    <= done_rsp;
          total_q  <= done_rsp.total_entries;
          cnt_q[0] <= done_rsp.md5_entries;
          cnt_q[1] <= done_rsp.sha1_entries;
          cnt_q[2] <= done_rsp.sha256_entries;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;
endmodule

### sv/dst_checker.sv
// port-level checks on the table's handshakes and counts
module dst_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input dst_pkg::rsp_t out_data_o
);
  import dst_pkg::*;

  // one transaction in flight: never ready while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // per-algorithm counts add up to the total
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.total_entries ==
      out_data_o.md5_entries + out_data_o.sha1_entries + out_data_o.sha256_entries)
    else $error("counts disagree");

  // found only on a clean status
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == StOk)
    else $error("found with error status");

  // busy once a transaction is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready right after accept");
endmodule

bind digest_signature_table dst_checker u_dst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
